[hdl/camc_pkg.sv]
// shared types, constants and functions for the cursor alpha-to-mask compositor
// no dependencies
`default_nettype none

package camc_pkg;

    localparam int unsigned PADDR_W = 4;

    localparam logic [7:0] THRESHOLD_BASE = 8'h60;
    localparam logic [7:0] FULL_BASE      = 8'hFF;
    localparam logic [7:0] LEFT_BIT       = 8'h80;

    // register indexes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_BYTES_PER_PIXEL    = 2'd0,
        REG_BITS_PER_COMPONENT = 2'd1,
        REG_ALPHA_IN_LAST_BYTE = 2'd2,
        REG_BLENDED_COMPONENTS = 2'd3
    } reg_idx_t;

    // clamped and decoded configuration; the user must keep it static while items are in flight (not enforced)
    typedef struct packed {
        logic [2:0]  bpp;        // 1..4
        logic [3:0]  bpc;        // 1..8
        logic [2:0]  shift;      // 8 - bpc
        logic [7:0]  full;       // 2^bpc - 1
        logic [7:0]  thr;        // 0x60 >> shift
        logic        alpha_last;
        logic [2:0]  blend;      // 0..4
        logic [16:0] recip;      // floor(65536 / full)
    } cfg_t;

    // first pipeline stage contents
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [7:0]      alpha;
        logic [3:0]      sel;
        logic            opaque;
        logic            mask_valid;
        logic [7:0]      mask_byte;
        logic            row_end;
    } front_t;

    // per-item flags carried beside the lane datapath
    typedef struct packed {
        logic       opaque;
        logic       mask_valid;
        logic [7:0] mask_byte;
        logic       row_end;
    } side_t;

    // load enables of the lane stages
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } pipe_en_t;

    function automatic logic [16:0] recip_of(input logic [3:0] bpc);
        logic [16:0] r;
        begin
            case (bpc)
                4'd1:    r = 17'd65536;
                4'd2:    r = 17'd21845;
                4'd3:    r = 17'd9362;
                4'd4:    r = 17'd4369;
                4'd5:    r = 17'd2114;
                4'd6:    r = 17'd1040;
                4'd7:    r = 17'd516;
                default: r = 17'd257;
            endcase
            return r;
        end
    endfunction

    function automatic cfg_t derive_cfg(input logic [2:0] bpp_raw,
                                        input logic [3:0] bpc_raw,
                                        input logic       alpha_last,
                                        input logic [2:0] blend_raw);
        cfg_t c;
        begin
            c.bpp = (bpp_raw == 3'd0) ? 3'd1 : ((bpp_raw > 3'd4) ? 3'd4 : bpp_raw);
            c.bpc = (bpc_raw == 4'd0) ? 4'd1 : ((bpc_raw > 4'd8) ? 4'd8 : bpc_raw);
            c.shift = 3'(4'd8 - c.bpc);
            c.full = FULL_BASE >> c.shift;
            c.thr = THRESHOLD_BASE >> c.shift;
            c.alpha_last = alpha_last;
            c.blend = (blend_raw > 3'd4) ? 3'd4 : blend_raw;
            c.recip = recip_of(c.bpc);
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/camc_regs.sv]
// configuration register file on the apb-style port
// depends on camc_pkg
`default_nettype none

module camc_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [camc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output camc_pkg::cfg_t                       cfg
);
    import camc_pkg::*;

    logic [2:0] bpp_reg;
    logic [3:0] bpc_reg;
    logic       alpha_last_reg;
    logic [2:0] blend_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg        <= 3'd4;
            bpc_reg        <= 4'd8;
            alpha_last_reg <= 1'b1;
            blend_reg      <= 3'd4;
        end else if (wr_en) begin
            unique case (idx)
                REG_BYTES_PER_PIXEL:    bpp_reg        <= pwdata[2:0];
                REG_BITS_PER_COMPONENT: bpc_reg        <= pwdata[3:0];
                REG_ALPHA_IN_LAST_BYTE: alpha_last_reg <= pwdata[0];
                REG_BLENDED_COMPONENTS: blend_reg      <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BYTES_PER_PIXEL:    prdata = {29'd0, bpp_reg};
            REG_BITS_PER_COMPONENT: prdata = {28'd0, bpc_reg};
            REG_ALPHA_IN_LAST_BYTE: prdata = {31'd0, alpha_last_reg};
            REG_BLENDED_COMPONENTS: prdata = {29'd0, blend_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg = derive_cfg(bpp_reg, bpc_reg, alpha_last_reg, blend_reg);

endmodule

`default_nettype wire

[hdl/camc_front.sv]
// alpha extraction, opacity test and mask byte packing; first pipeline stage
// depends on camc_pkg
`default_nettype none

module camc_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [31:0]    pixel_bytes,
    input  wire logic           row_end,
    input  wire camc_pkg::cfg_t cfg,
    output camc_pkg::front_t    front
);
    import camc_pkg::*;

    logic [7:0]      acc_reg, acc_next;
    logic [2:0]      pos_reg, pos_next;
    front_t          front_reg, front_next;
    logic [3:0][7:0] bytes;
    logic [1:0]      alpha_idx;
    logic [7:0]      alpha;
    logic            opaque;
    logic            blend_en;
    logic            last;
    logic [7:0]      acc_or;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            bytes[i] = (3'(i) < cfg.bpp) ? pixel_bytes[8*i +: 8] : 8'd0;
        end
        alpha_idx = cfg.alpha_last ? 2'(cfg.bpp - 3'd1) : 2'd0;
        alpha     = bytes[alpha_idx] >> cfg.shift;
        opaque    = alpha > cfg.thr;
        blend_en  = opaque && (cfg.bpp == 3'd4) && (alpha != cfg.full);
        acc_or    = opaque ? (acc_reg | (LEFT_BIT >> pos_reg)) : acc_reg;
        last      = (pos_reg == 3'd7) || row_end;

        front_next.bytes      = bytes;
        front_next.alpha      = alpha;
        for (int i = 0; i < 4; i++) begin
            front_next.sel[i] = blend_en && (3'(i) < cfg.blend);
        end
        front_next.opaque     = opaque;
        front_next.mask_valid = last;
        front_next.mask_byte  = last ? acc_or : 8'd0;
        front_next.row_end    = row_end;

        acc_next = acc_reg;
        pos_next = pos_reg;
        if (accept) begin
            acc_next = last ? 8'd0 : acc_or;
            pos_next = last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 8'd0;
            pos_reg <= 3'd0;
        end else begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

[hdl/camc_lane.sv]
// one byte lane of the composite over white: product, reciprocal divide,
// correction and select; depends on camc_pkg
`default_nettype none

module camc_lane (
    input  wire logic              aclk,
    input  wire camc_pkg::pipe_en_t en,
    input  wire camc_pkg::cfg_t    cfg,
    input  wire logic [7:0]        byte_in,
    input  wire logic [7:0]        alpha_in,
    input  wire logic              sel_in,
    output logic      [7:0]        byte_out
);
    import camc_pkg::*;

    // stage 2
    logic [15:0] prod2_reg;
    logic [7:0]  byte2_reg;
    logic [7:0]  alpha2_reg;
    logic        sel2_reg;
    // stage 3
    logic [15:0] prod3_reg;
    logic [7:0]  q0_reg, q0_next;
    logic [7:0]  byte3_reg;
    logic [7:0]  alpha3_reg;
    logic        sel3_reg;
    logic [32:0] recip_prod;
    // stage 4
    logic [7:0]  out_reg, out_next;
    logic [15:0] q0_times_full;
    logic [15:0] rem;
    logic [7:0]  quot;
    logic [8:0]  comp;

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            prod2_reg  <= byte_in * alpha_in;
            byte2_reg  <= byte_in;
            alpha2_reg <= alpha_in;
            sel2_reg   <= sel_in;
        end
    end

    // floor(p * floor(2^16/full) / 2^16) is the quotient or one short of it
    assign recip_prod = 33'(prod2_reg) * 33'(cfg.recip);
    assign q0_next    = recip_prod[23:16];

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            prod3_reg  <= prod2_reg;
            q0_reg     <= q0_next;
            byte3_reg  <= byte2_reg;
            alpha3_reg <= alpha2_reg;
            sel3_reg   <= sel2_reg;
        end
    end

    always_comb begin
        // q0 * (2^bpc - 1) as shift and subtract
        q0_times_full = (16'(q0_reg) << cfg.bpc) - 16'(q0_reg);
        rem  = prod3_reg - q0_times_full;
        quot = (rem >= 16'(cfg.full)) ? q0_reg + 8'd1 : q0_reg;
        comp = 9'(cfg.full) - 9'(alpha3_reg) + 9'(quot);
        out_next = sel3_reg ? comp[7:0] : byte3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.en4) begin
            out_reg <= out_next;
        end
    end

    assign byte_out = out_reg;

endmodule

`default_nettype wire

[hdl/cursor_alpha_to_mask_composite.sv]
// Cursor alpha-to-mask converter with compositing over white.
// Input: s_valid/s_ready with s_pixel_bytes (memory order, byte 0 in bits 7:0)
// and s_row_end marking the last pixel of a cursor row. Output: m_valid/m_ready
// with one result per request: the pixel (composited over white in 32-bit mode
// when partly opaque), its opacity bit, and the packed mask byte which is valid
// after every eighth pixel and at row end.
// From the accepting edge to m_valid a request passes four stages: one
// for alpha, compare and mask packing, then three per-lane stages (alpha product,
// reciprocal multiply divide, correction and select). Throughput is one request
// per cycle while m_ready is high; the two multiplier stages set the depth.
// Each stage loads when it is empty or the stage after it moves, so when the
// receiver stalls the bubbles fill up and s_ready drops only once all four
// stages hold requests.
// Reset (aresetn low, synchronous) empties the pipeline, clears the mask
// accumulator and bit position, and loads the register defaults.
// Configuration is to be written through the apb-style port only while idle; the block does not enforce it.
// depends on camc_pkg, camc_regs, camc_front, camc_lane
`default_nettype none

module cursor_alpha_to_mask_composite (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [camc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [31:0]                  s_pixel_bytes,
    input  wire logic                         s_row_end,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [31:0]                  m_pixel_out,
    output logic                              m_is_opaque,
    output logic                              m_mask_valid,
    output logic      [7:0]                   m_mask_byte,
    output logic                              m_row_end_out
);
    import camc_pkg::*;

    cfg_t     cfg;
    front_t   front;
    pipe_en_t en;
    logic     en1;
    logic     accept;
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    side_t    side1, side2_reg, side3_reg, side4_reg;
    logic [3:0][7:0] lane_out;

    camc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // per-stage enables: a stage moves when empty or when its successor moves
    assign en.en4  = !v4_reg || m_ready;
    assign en.en3  = !v3_reg || en.en4;
    assign en.en2  = !v2_reg || en.en3;
    assign en1     = !v1_reg || en.en2;
    assign s_ready = en1;
    assign accept  = s_valid && s_ready;

    camc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pixel_bytes (s_pixel_bytes),
        .row_end     (s_row_end),
        .cfg         (cfg),
        .front       (front)
    );

    for (genvar i = 0; i < 4; i++) begin : g_lane
        camc_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .cfg      (cfg),
            .byte_in  (front.bytes[i]),
            .alpha_in (front.alpha),
            .sel_in   (front.sel[i]),
            .byte_out (lane_out[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg <= accept;
            if (en.en2) v2_reg <= v1_reg;
            if (en.en3) v3_reg <= v2_reg;
            if (en.en4) v4_reg <= v3_reg;
        end
    end

    always_comb begin
        side1.opaque     = front.opaque;
        side1.mask_valid = front.mask_valid;
        side1.mask_byte  = front.mask_byte;
        side1.row_end    = front.row_end;
    end

    always_ff @(posedge aclk) begin
        if (en.en2) side2_reg <= side1;
        if (en.en3) side3_reg <= side2_reg;
        if (en.en4) side4_reg <= side3_reg;
    end

    assign m_valid       = v4_reg;
    assign m_pixel_out   = lane_out;
    assign m_is_opaque   = side4_reg.opaque;
    assign m_mask_valid  = side4_reg.mask_valid;
    assign m_mask_byte   = side4_reg.mask_byte;
    assign m_row_end_out = side4_reg.row_end;

    // an empty output stage never backs up the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !v4_reg |-> s_ready)
        else $error("s_ready low with empty output stage");

    // a partial mask byte is reported as zero
    a_mask_zero_when_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_mask_valid) |-> (m_mask_byte == 8'd0))
        else $error("mask byte nonzero while incomplete");

    // row end always closes the mask byte
    a_row_end_closes_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_end_out) |-> m_mask_valid)
        else $error("row end without mask byte");

    // bytes above a one-byte pixel stay zero
    a_unused_bytes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg.bpp == 3'd1) |-> (m_pixel_out[31:8] == 24'd0))
        else $error("unused pixel bytes not zero");

    // a stalled result holds its pixel across the stall
    a_stall_holds_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_out)))
        else $error("result changed under stall");

endmodule

`default_nettype wire
